/* sv/act_pkg.sv */
// Package for the AABB contact tracker: event codes, controller states,
// command and status bundles, mask reset value and the kind-pair lookup.
// No dependencies; used by act_ctrl, act_dp and aabb_contact_tracker_top.
package act_pkg;

  localparam int KIND_BITS = 3;
  localparam int DIM_BITS  = 10;
  localparam int KINDS     = 7;
  localparam int MASK_BITS = 49;

  localparam logic [MASK_BITS-1:0] PAIR_MASK_RST = 49'd8865357937152;
  localparam logic [KIND_BITS-1:0] KIND_INVALID  = 3'd7;

  typedef enum logic [1:0] {
    EV_BEGIN = 2'd0,
    EV_STAY  = 2'd1,
    EV_END   = 2'd2,
    EV_NONE  = 2'd3
  } ev_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_EVAL,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic rd;
    logic eval;
    logic push_a;
    logic push_b;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pair_present;
    logic ev_a_v;
    logic ev_b_v;
    logic can_push;
    logic out_free;
  } status_t;

  // Kind a reacts to kind b; kind seven has no mask bits.
  function automatic logic reacts(logic [MASK_BITS-1:0] mask,
                                  logic [KIND_BITS-1:0] a,
                                  logic [KIND_BITS-1:0] b);
    logic [5:0] idx;
    idx = 6'(a) * 6'(KINDS) + 6'(b);
    if (a == KIND_INVALID || b == KIND_INVALID) begin
      return 1'b0;
    end
    return mask[idx];
  endfunction

endpackage

/* sv/act_ctrl.sv */
// Controller for the AABB contact tracker: load/scan state machine and
// pair counters. Depends on act_pkg.
module act_ctrl #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_last_item,
  output logic                                  in_stall,
  input  act_pkg::status_t                      st,
  output act_pkg::cmd_t                         cmd,
  output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] j_idx,
  output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] k_idx
);

  localparam int SLOT_IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [SLOT_IW-1:0] LAST_K = SLOT_IW'(MAX_SLOTS - 1);
  localparam logic [SLOT_IW-1:0] LAST_J = SLOT_IW'(MAX_SLOTS - 2);

  act_pkg::state_t state_r, state_nxt;
  logic [SLOT_IW-1:0] j_r, j_nxt, k_r, k_nxt;
  logic adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= act_pkg::ST_IDLE;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    adv       = 1'b0;
    case (state_r)
      act_pkg::ST_IDLE: begin
        if (in_valid && in_last_item) begin
          state_nxt = act_pkg::ST_PAIR;
          j_nxt     = '0;
          k_nxt     = SLOT_IW'(1);
        end
      end
      act_pkg::ST_PAIR: begin
        if (st.pair_present) begin
          cmd.rd    = 1'b1;
          state_nxt = act_pkg::ST_EVAL;
        end else begin
          adv = 1'b1;
        end
      end
      act_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = act_pkg::ST_EMIT_A;
      end
      act_pkg::ST_EMIT_A: begin
        if (!st.ev_a_v) begin
          state_nxt = act_pkg::ST_EMIT_B;
        end else if (st.can_push) begin
          cmd.push_a = 1'b1;
          state_nxt  = act_pkg::ST_EMIT_B;
        end
      end
      act_pkg::ST_EMIT_B: begin
        if (!st.ev_b_v) begin
          adv = 1'b1;
        end else if (st.can_push) begin
          cmd.push_b = 1'b1;
          adv        = 1'b1;
        end
      end
      act_pkg::ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = act_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = act_pkg::ST_IDLE;
      end
    endcase

    // Advance to the next pair j < k, or close the frame.
    if (adv) begin
      if (k_r == LAST_K) begin
        if (j_r == LAST_J) begin
          state_nxt = act_pkg::ST_FINISH;
        end else begin
          j_nxt     = j_r + SLOT_IW'(1);
          k_nxt     = j_r + SLOT_IW'(2);
          state_nxt = act_pkg::ST_PAIR;
        end
      end else begin
        k_nxt     = k_r + SLOT_IW'(1);
        state_nxt = act_pkg::ST_PAIR;
      end
    end
  end

  assign in_stall = (state_r != act_pkg::ST_IDLE);
  assign j_idx    = j_r;
  assign k_idx    = k_r;

endmodule

/* sv/act_dp.sv */
// Datapath for the AABB contact tracker: slot table memory, present bits,
// contact marks, overlap test, event hold stage and output register.
// Depends on act_pkg.
module act_dp #(
  parameter int MAX_SLOTS  = 8,
  parameter int COORD_BITS = 11
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_write_en,
  input  logic [act_pkg::MASK_BITS-1:0]         cfg_wdata,
  input  logic                                  in_accept,
  input  logic [2:0]                            in_slot,
  input  logic                                  in_present,
  input  logic signed [COORD_BITS-1:0]          in_pos_x,
  input  logic signed [COORD_BITS-1:0]          in_pos_y,
  input  logic [act_pkg::DIM_BITS-1:0]          in_width,
  input  logic [act_pkg::DIM_BITS-1:0]          in_height,
  input  logic [act_pkg::KIND_BITS-1:0]         in_kind,
  input  logic                                  in_has_listener,
  input  logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] j_idx,
  input  logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] k_idx,
  input  act_pkg::cmd_t                         cmd,
  output act_pkg::status_t                      st,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            out_event_kind,
  output logic [2:0]                            out_receiver,
  output logic [2:0]                            out_other,
  output logic                                  out_last_event
);

  localparam int SLOT_IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int DB      = act_pkg::DIM_BITS;
  localparam int KB      = act_pkg::KIND_BITS;
  localparam int REC_W   = 2 * COORD_BITS + 2 * DB + KB + 1;
  localparam int KIND_LO = 1;
  localparam int H_LO    = KIND_LO + KB;
  localparam int W_LO    = H_LO + DB;
  localparam int Y_LO    = W_LO + DB;
  localparam int X_LO    = Y_LO + COORD_BITS;
  localparam int SUM_W   = ((COORD_BITS > DB) ? COORD_BITS : DB + 1) + 1;

  logic [act_pkg::MASK_BITS-1:0] pair_mask_r;
  logic [REC_W-1:0]              slot_mem [MAX_SLOTS];
  logic [REC_W-1:0]              rec_j_r, rec_k_r;
  logic [MAX_SLOTS-1:0]          present_r;
  logic [MAX_SLOTS-1:0]          marks_r [MAX_SLOTS];

  logic               slot_ok;
  logic [SLOT_IW-1:0] slot_idx;

  logic signed [COORD_BITS-1:0] xj_raw, yj_raw, xk_raw, yk_raw;
  logic signed [SUM_W-1:0] xj, yj, xk, yk, wj, hj, wk, hk;
  logic signed [SUM_W-1:0] xj_end, yj_end, xk_end, yk_end;
  logic                    ovl;
  logic [KB-1:0]           kind_j, kind_k;
  logic                    lis_j, lis_k;
  logic                    mark_a, mark_b, mark_a_nxt, mark_b_nxt;
  logic                    react_a, react_b;
  logic                    ev_a_v_nxt, ev_b_v_nxt;
  act_pkg::ev_kind_t       ev_a_kind_nxt, ev_b_kind_nxt;

  logic              ev_a_v_r, ev_b_v_r;
  act_pkg::ev_kind_t ev_a_kind_r, ev_b_kind_r;

  logic              held_v_r;
  act_pkg::ev_kind_t held_kind_r;
  logic [2:0]        held_recv_r, held_oth_r;
  logic              out_valid_r, out_last_r;
  act_pkg::ev_kind_t out_kind_r;
  logic [2:0]        out_recv_r, out_oth_r;

  logic              push;
  act_pkg::ev_kind_t push_kind;
  logic [2:0]        push_recv, push_oth;
  logic              out_free;

  assign slot_ok  = ({1'b0, in_slot} < 4'(MAX_SLOTS));
  assign slot_idx = in_slot[SLOT_IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_mask_r <= act_pkg::PAIR_MASK_RST;
    end else if (cfg_write_en) begin
      pair_mask_r <= cfg_wdata;
    end
  end

  // Slot table: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (in_accept && slot_ok && in_present) begin
      slot_mem[slot_idx] <= {in_pos_x, in_pos_y, in_width, in_height, in_kind,
                             in_has_listener};
    end
    if (cmd.rd) begin
      rec_j_r <= slot_mem[j_idx];
      rec_k_r <= slot_mem[k_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        marks_r[i] <= '0;
      end
    end else begin
      if (in_accept && slot_ok) begin
        present_r[slot_idx] <= in_present;
        if (!in_present) begin
          marks_r[slot_idx] <= '0;
          for (int i = 0; i < MAX_SLOTS; i++) begin
            marks_r[i][slot_idx] <= 1'b0;
          end
        end
      end
      if (cmd.eval) begin
        marks_r[j_idx][k_idx] <= mark_a_nxt;
        marks_r[k_idx][j_idx] <= mark_b_nxt;
      end
    end
  end

  // Overlap test on the two registered records.
  assign xj_raw = rec_j_r[X_LO +: COORD_BITS];
  assign yj_raw = rec_j_r[Y_LO +: COORD_BITS];
  assign xk_raw = rec_k_r[X_LO +: COORD_BITS];
  assign yk_raw = rec_k_r[Y_LO +: COORD_BITS];
  assign xj = SUM_W'(xj_raw);
  assign yj = SUM_W'(yj_raw);
  assign xk = SUM_W'(xk_raw);
  assign yk = SUM_W'(yk_raw);
  assign wj = SUM_W'(rec_j_r[W_LO +: DB]);
  assign hj = SUM_W'(rec_j_r[H_LO +: DB]);
  assign wk = SUM_W'(rec_k_r[W_LO +: DB]);
  assign hk = SUM_W'(rec_k_r[H_LO +: DB]);
  assign xj_end = xj + wj;
  assign yj_end = yj + hj;
  assign xk_end = xk + wk;
  assign yk_end = yk + hk;
  assign ovl = (xj < xk_end) && (xj_end > xk) && (yj < yk_end) && (yj_end > yk);

  assign kind_j  = rec_j_r[KIND_LO +: KB];
  assign kind_k  = rec_k_r[KIND_LO +: KB];
  assign lis_j   = rec_j_r[0];
  assign lis_k   = rec_k_r[0];
  assign mark_a  = marks_r[j_idx][k_idx];
  assign mark_b  = marks_r[k_idx][j_idx];
  assign react_a = act_pkg::reacts(pair_mask_r, kind_j, kind_k) && lis_j;
  assign react_b = act_pkg::reacts(pair_mask_r, kind_k, kind_j) && lis_k;

  always_comb begin
    ev_a_v_nxt    = 1'b0;
    ev_a_kind_nxt = act_pkg::EV_BEGIN;
    mark_a_nxt    = mark_a;
    ev_b_v_nxt    = 1'b0;
    ev_b_kind_nxt = act_pkg::EV_BEGIN;
    mark_b_nxt    = mark_b;
    if (ovl) begin
      if (react_a) begin
        ev_a_v_nxt    = 1'b1;
        ev_a_kind_nxt = mark_a ? act_pkg::EV_STAY : act_pkg::EV_BEGIN;
        mark_a_nxt    = 1'b1;
      end
      if (react_b) begin
        ev_b_v_nxt    = 1'b1;
        ev_b_kind_nxt = mark_b ? act_pkg::EV_STAY : act_pkg::EV_BEGIN;
        mark_b_nxt    = 1'b1;
      end
    end else begin
      if (mark_a) begin
        ev_a_v_nxt    = 1'b1;
        ev_a_kind_nxt = act_pkg::EV_END;
        mark_a_nxt    = 1'b0;
      end
      if (mark_b) begin
        ev_b_v_nxt    = 1'b1;
        ev_b_kind_nxt = act_pkg::EV_END;
        mark_b_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_a_v_r <= 1'b0;
      ev_b_v_r <= 1'b0;
    end else if (cmd.eval) begin
      ev_a_v_r <= ev_a_v_nxt;
      ev_b_v_r <= ev_b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ev_a_kind_r <= ev_a_kind_nxt;
      ev_b_kind_r <= ev_b_kind_nxt;
    end
  end

  // Hold the newest event back one step so the frame's last one is known.
  assign out_free  = !out_valid_r || !out_stall;
  assign push      = cmd.push_a || cmd.push_b;
  assign push_kind = cmd.push_a ? ev_a_kind_r : ev_b_kind_r;
  assign push_recv = cmd.push_a ? 3'(j_idx) : 3'(k_idx);
  assign push_oth  = cmd.push_a ? 3'(k_idx) : 3'(j_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_v_r    <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (push) begin
        if (held_v_r) begin
          out_valid_r <= 1'b1;
        end
        held_v_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        held_v_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (held_v_r) begin
        out_kind_r <= held_kind_r;
        out_recv_r <= held_recv_r;
        out_oth_r  <= held_oth_r;
        out_last_r <= 1'b0;
      end
      held_kind_r <= push_kind;
      held_recv_r <= push_recv;
      held_oth_r  <= push_oth;
    end
    if (cmd.finish) begin
      out_last_r <= 1'b1;
      if (held_v_r) begin
        out_kind_r <= held_kind_r;
        out_recv_r <= held_recv_r;
        out_oth_r  <= held_oth_r;
      end else begin
        out_kind_r <= act_pkg::EV_NONE;
        out_recv_r <= '0;
        out_oth_r  <= '0;
      end
    end
  end

  assign st.pair_present = present_r[j_idx] && present_r[k_idx];
  assign st.ev_a_v       = ev_a_v_r;
  assign st.ev_b_v       = ev_b_v_r;
  assign st.can_push     = !held_v_r || out_free;
  assign st.out_free     = out_free;

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_receiver   = out_recv_r;
  assign out_other      = out_oth_r;
  assign out_last_event = out_last_r;

endmodule

/* sv/aabb_contact_tracker_top.sv */
// Top level of the AABB contact tracker: joins the controller and datapath.
// Depends on act_pkg, act_ctrl and act_dp.
//
// The host loads one transaction per collider slot, one per cycle, in slot
// order; a slot loaded absent drops every contact mark it is part of. The
// transaction carrying in_last_item starts the pair scan, and the input
// stalls until the scan has handed its final event to the output register.
// The scan walks every pair j < k of the MAX_SLOTS slots: a pair with an
// absent slot is skipped, a pair of present slots passes through a two-port
// slot table read, overlap evaluation and one state for each direction's
// event, where each event waits while the output is stalled, and closing
// the frame ends the scan.
// Events come out as begin, stay or end with receiver and other slot; the
// last one of a frame has out_last_event set, and a frame without events
// gives a single transaction with event kind "none". pair_mask bit a*7+b
// lets kind a react to kind b; write it through cfg_write_en while idle.
module aabb_contact_tracker_top #(
  parameter int MAX_SLOTS  = 8,
  parameter int COORD_BITS = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_write_en,
  input  logic [act_pkg::MASK_BITS-1:0] cfg_wdata,
  // slot load channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_slot,
  input  logic                          in_present,
  input  logic signed [COORD_BITS-1:0]  in_pos_x,
  input  logic signed [COORD_BITS-1:0]  in_pos_y,
  input  logic [act_pkg::DIM_BITS-1:0]  in_width,
  input  logic [act_pkg::DIM_BITS-1:0]  in_height,
  input  logic [act_pkg::KIND_BITS-1:0] in_kind,
  input  logic                          in_has_listener,
  input  logic                          in_last_item,
  // event channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_event_kind,
  output logic [2:0]                    out_receiver,
  output logic [2:0]                    out_other,
  output logic                          out_last_event
);

  localparam int SLOT_IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  act_pkg::cmd_t      cmd;
  act_pkg::status_t   st;
  logic [SLOT_IW-1:0] j_idx, k_idx;
  logic               in_accept;

  assign in_accept = in_valid && !in_stall;

  // Sequence loading, the pair scan and frame close.
  act_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .in_stall     (in_stall),
    .st           (st),
    .cmd          (cmd),
    .j_idx        (j_idx),
    .k_idx        (k_idx)
  );

  // Store slots, track marks, test overlap and drive the event register.
  act_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_wdata       (cfg_wdata),
    .in_accept       (in_accept),
    .in_slot         (in_slot),
    .in_present      (in_present),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_width        (in_width),
    .in_height       (in_height),
    .in_kind         (in_kind),
    .in_has_listener (in_has_listener),
    .j_idx           (j_idx),
    .k_idx           (k_idx),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_receiver    (out_receiver),
    .out_other       (out_other),
    .out_last_event  (out_last_event)
  );

`ifndef SYNTHESIS
  // A final slot transaction must start the scan and block further loads.
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_last_item |=> in_stall)
    else $error("scan did not start after last slot");

  // An event push must never overwrite a result still waiting at the output.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_a || cmd.push_b) |-> st.can_push)
    else $error("event pushed with no room");

  // Frame close only when the output register can take the final event.
  a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> st.out_free)
    else $error("frame closed over a pending result");

  // Evaluation uses records read in the cycle before.
  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> $past(cmd.rd))
    else $error("evaluation without slot read");
`endif

endmodule
